// ===== src/bpp_pkg.sv =====
// Shared types, constants and fixed-point helpers for the Boris particle pusher.
package bpp_pkg;

    localparam int FRAC_BITS = 16;
    // Rounded product width (signed), wide work width, quotient bits,
    // denominator width and dividend width.
    localparam int RW = 65 - FRAC_BITS;
    localparam int WW = 68;
    localparam int QB = FRAC_BITS + 2;
    localparam int DW = 66 - FRAC_BITS;
    localparam int NW = 67;

    localparam logic [64:0] HALF65 = 65'(1) << (FRAC_BITS - 1);
    localparam logic [65:0] ONE66 = 66'(1) << FRAC_BITS;
    localparam logic signed [WW-1:0] SMAX = WW'(64'sd2147483647);
    localparam logic signed [WW-1:0] SMIN = ~SMAX;

    // Register index codes
    localparam logic REG_KICK = 1'b0;
    localparam logic REG_DT = 1'b1;

    typedef logic signed [31:0] t_q;

    typedef struct packed {
        t_q pos_x;
        t_q pos_y;
        t_q pos_z;
        t_q vel_x;
        t_q vel_y;
        t_q vel_z;
        t_q flow_x;
        t_q flow_y;
        t_q flow_z;
        t_q field_x;
        t_q field_y;
        t_q field_z;
    } t_push_in;

    typedef struct packed {
        t_q new_pos_x;
        t_q new_pos_y;
        t_q new_pos_z;
        t_q new_vel_x;
        t_q new_vel_y;
        t_q new_vel_z;
    } t_push_out;

    // Exact magnitude product with its sign, before rounding
    typedef struct packed {
        logic        neg;
        logic [63:0] mag;
    } t_prod;

    function automatic logic [31:0] mag32(input logic [31:0] a);
        return a[31] ? (~a + 32'd1) : a;
    endfunction

    function automatic t_prod pmul(input logic [31:0] a, input logic [31:0] bm,
                                   input logic bneg);
        t_prod p;
        p.neg = a[31] ^ bneg;
        p.mag = {32'd0, mag32(a)} * {32'd0, bm};
        return p;
    endfunction

    // Round magnitude to nearest, ties away from zero, then reapply sign
    function automatic logic signed [RW-1:0] prnd(input t_prod p);
        logic [64:0]   m;
        logic [RW-1:0] r;
        m = {1'b0, p.mag} + HALF65;
        r = RW'(m >> FRAC_BITS);
        return p.neg ? -$signed(r) : $signed(r);
    endfunction

    function automatic t_q sat32(input logic signed [WW-1:0] v);
        if (v > SMAX) begin
            return 32'sh7fff_ffff;
        end else if (v < SMIN) begin
            return 32'sh8000_0000;
        end else begin
            return v[31:0];
        end
    endfunction

endpackage

// ===== src/boris_particle_push.sv =====
// Boris particle pusher: one fully pipelined step per particle.
// A result strobes on o_valid once a taken start has passed through the pipeline
//   (6 arithmetic stages, 18 divider stages, 8 rotation and update stages).
// Throughput: one particle per cycle; busy stays low, results cannot be held off.
// The quotient for the rotation vector is formed one bit per pipeline stage.
// Reset (synchronous, active low) clears in-flight valids and both registers.
module boris_particle_push
    import bpp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_push_in    i_item,
    output logic        o_valid,
    output t_push_out   o_result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int NST = 14 + QB;
    localparam int NXT [3] = '{1, 2, 0};
    localparam int PRV [3] = '{2, 0, 1};

    typedef struct packed {
        logic [2:0][31:0] x;
        logic [2:0][31:0] u;
        logic [2:0][31:0] r;
        logic [2:0][31:0] t;
    } t_side;

    logic [31:0]     r_kick;
    logic [31:0]     r_dt;
    logic [NST-1:0]  r_vld;

    // front stages
    t_push_in        r_s1;
    t_q              a_p [3];
    t_q              a_v [3];
    t_q              a_u [3];
    t_q              a_b [3];
    t_prod           r_ubp [3][2];
    t_prod           r_tkp [3];
    t_q              r_x2 [3];
    t_q              r_v2 [3];
    t_q              r_uxb3 [3];
    t_q              r_t3 [3];
    t_q              r_x3 [3];
    t_q              r_v3 [3];
    t_prod           r_rkp4 [3];
    logic [63:0]     r_tsq4 [3];
    t_q              r_t4 [3];
    t_q              r_x4 [3];
    t_q              r_v4 [3];
    t_q              r_r5 [3];
    logic [DW-1:0]   r_den5;
    t_q              r_t5 [3];
    t_q              r_x5 [3];
    t_q              r_v5 [3];
    logic [65:0]     w_sq;
    logic [65:0]     w_den66;
    logic [NW-1:0]   r_n6 [3];
    logic [DW-1:0]   r_den6;
    t_side           r_side6;

    // divider stages
    logic [NW-1:0]   r_rem [QB][3];
    logic [QB-1:0]   r_q [QB][3];
    logic [DW-1:0]   r_dden [QB];
    t_side           r_side [QB];
    logic [NW-1:0]   w_rem_in [QB][3];
    logic [QB-1:0]   w_q_in [QB][3];
    logic [DW-1:0]   w_den_in [QB];
    t_side           w_side_in [QB];

    // back stages
    t_q              w_dx [3];
    t_q              w_du [3];
    t_q              w_dr [3];
    t_q              w_dt [3];
    logic signed [WW-1:0] w_qw [3];
    t_q              r_s_p1 [3];
    t_prod           r_c1p_p1 [3][2];
    t_q              r_x_p1 [3];
    t_q              r_u_p1 [3];
    t_q              r_r_p1 [3];
    t_q              r_c1_p2 [3];
    t_q              r_s_p2 [3];
    t_q              r_x_p2 [3];
    t_q              r_u_p2 [3];
    t_q              r_r_p2 [3];
    t_q              r_vp_p3 [3];
    t_q              r_s_p3 [3];
    t_q              r_x_p3 [3];
    t_q              r_u_p3 [3];
    t_q              r_r_p3 [3];
    t_prod           r_c2p_p4 [3][2];
    t_q              r_x_p4 [3];
    t_q              r_u_p4 [3];
    t_q              r_r_p4 [3];
    t_q              r_c2_p5 [3];
    t_q              r_x_p5 [3];
    t_q              r_u_p5 [3];
    t_q              r_r_p5 [3];
    t_q              w_w [3];
    t_q              r_vn_p6 [3];
    t_q              r_x_p6 [3];
    t_prod           r_dtp_p7 [3];
    t_q              r_vn_p7 [3];
    t_q              r_x_p7 [3];
    t_push_out       r_out;

    // ---------------- control and configuration ----------------
    assign busy    = 1'b0;
    assign pready  = 1'b1;
    assign o_valid = r_vld[NST-1];
    assign o_result = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_kick <= '0;
            r_dt   <= '0;
        end else begin
            r_vld <= {r_vld[NST-2:0], start & ~busy};
            if (psel && penable && pwrite && pready) begin
                unique case (paddr[2])
                    REG_KICK: r_kick <= pwdata;
                    REG_DT:   r_dt   <= pwdata;
                endcase
            end
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_KICK: prdata = r_kick;
            REG_DT:   prdata = r_dt;
        endcase
    end

    // ---------------- combinational helpers ----------------
    always_comb begin
        a_p[0] = r_s1.pos_x;   a_p[1] = r_s1.pos_y;   a_p[2] = r_s1.pos_z;
        a_v[0] = r_s1.vel_x;   a_v[1] = r_s1.vel_y;   a_v[2] = r_s1.vel_z;
        a_u[0] = r_s1.flow_x;  a_u[1] = r_s1.flow_y;  a_u[2] = r_s1.flow_z;
        a_b[0] = r_s1.field_x; a_b[1] = r_s1.field_y; a_b[2] = r_s1.field_z;
    end

    always_comb begin
        w_sq = 66'(r_tsq4[0]) + 66'(r_tsq4[1]) + 66'(r_tsq4[2]) + 66'(HALF65);
        w_den66 = (w_sq >> FRAC_BITS) + ONE66;
    end

    always_comb begin
        w_den_in[0]  = r_den6;
        w_side_in[0] = r_side6;
        for (int i = 0; i < 3; i++) begin
            w_rem_in[0][i] = r_n6[i];
            w_q_in[0][i]   = '0;
        end
        for (int d = 1; d < QB; d++) begin
            w_den_in[d]  = r_dden[d-1];
            w_side_in[d] = r_side[d-1];
            for (int i = 0; i < 3; i++) begin
                w_rem_in[d][i] = r_rem[d-1][i];
                w_q_in[d][i]   = r_q[d-1][i];
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_dx[i] = r_side[QB-1].x[i];
            w_du[i] = r_side[QB-1].u[i];
            w_dr[i] = r_side[QB-1].r[i];
            w_dt[i] = r_side[QB-1].t[i];
            w_qw[i] = WW'(r_q[QB-1][i]);
            w_w[i]  = sat32(WW'(r_u_p5[i]) + WW'(r_c2_p5[i]));
        end
    end

    // ---------------- datapath ----------------
    always_ff @(posedge i_clk) begin
        r_s1 <= i_item;

        for (int i = 0; i < 3; i++) begin
            // U x B products and B*k
            r_ubp[i][0] <= pmul(a_u[NXT[i]], mag32(a_b[PRV[i]]), a_b[PRV[i]][31]);
            r_ubp[i][1] <= pmul(a_u[PRV[i]], mag32(a_b[NXT[i]]), a_b[NXT[i]][31]);
            r_tkp[i]    <= pmul(a_b[i], r_kick, 1'b0);
            r_x2[i]     <= a_p[i];
            r_v2[i]     <= a_v[i];

            r_uxb3[i] <= sat32(WW'(prnd(r_ubp[i][0])) - WW'(prnd(r_ubp[i][1])));
            r_t3[i]   <= sat32(WW'(prnd(r_tkp[i])));
            r_x3[i]   <= r_x2[i];
            r_v3[i]   <= r_v2[i];

            r_rkp4[i] <= pmul(r_uxb3[i], r_kick, 1'b0);
            r_tsq4[i] <= {32'd0, mag32(r_t3[i])} * {32'd0, mag32(r_t3[i])};
            r_t4[i]   <= r_t3[i];
            r_x4[i]   <= r_x3[i];
            r_v4[i]   <= r_v3[i];

            // half kick is the negated product
            r_r5[i] <= sat32(-WW'(prnd(r_rkp4[i])));
            r_t5[i] <= r_t4[i];
            r_x5[i] <= r_x4[i];
            r_v5[i] <= r_v4[i];

            // dividend: 2|T| scaled, plus half the denominator for rounding
            r_n6[i] <= (NW'(mag32(r_t5[i])) << (FRAC_BITS + 1)) + NW'(r_den5 >> 1);
            r_side6.x[i] <= r_x5[i];
            r_side6.u[i] <= sat32(WW'(r_v5[i]) + WW'(r_r5[i]));
            r_side6.r[i] <= r_r5[i];
            r_side6.t[i] <= r_t5[i];
        end
        r_den5 <= w_den66[DW-1:0];
        r_den6 <= r_den5;

        // restoring divider, one quotient bit per stage, MSB first
        for (int d = 0; d < QB; d++) begin
            r_dden[d] <= w_den_in[d];
            r_side[d] <= w_side_in[d];
            for (int i = 0; i < 3; i++) begin
                if (w_rem_in[d][i] >= (NW'(w_den_in[d]) << (QB - 1 - d))) begin
                    r_rem[d][i] <= w_rem_in[d][i] - (NW'(w_den_in[d]) << (QB - 1 - d));
                    r_q[d][i]   <= {w_q_in[d][i][QB-2:0], 1'b1};
                end else begin
                    r_rem[d][i] <= w_rem_in[d][i];
                    r_q[d][i]   <= {w_q_in[d][i][QB-2:0], 1'b0};
                end
            end
        end

        for (int i = 0; i < 3; i++) begin
            r_s_p1[i] <= sat32(w_dt[i][31] ? -w_qw[i] : w_qw[i]);
            r_c1p_p1[i][0] <= pmul(w_du[NXT[i]], mag32(w_dt[PRV[i]]), w_dt[PRV[i]][31]);
            r_c1p_p1[i][1] <= pmul(w_du[PRV[i]], mag32(w_dt[NXT[i]]), w_dt[NXT[i]][31]);
            r_x_p1[i] <= w_dx[i];
            r_u_p1[i] <= w_du[i];
            r_r_p1[i] <= w_dr[i];

            r_c1_p2[i] <= sat32(WW'(prnd(r_c1p_p1[i][0])) - WW'(prnd(r_c1p_p1[i][1])));
            r_s_p2[i]  <= r_s_p1[i];
            r_x_p2[i]  <= r_x_p1[i];
            r_u_p2[i]  <= r_u_p1[i];
            r_r_p2[i]  <= r_r_p1[i];

            r_vp_p3[i] <= sat32(WW'(r_u_p2[i]) + WW'(r_c1_p2[i]));
            r_s_p3[i]  <= r_s_p2[i];
            r_x_p3[i]  <= r_x_p2[i];
            r_u_p3[i]  <= r_u_p2[i];
            r_r_p3[i]  <= r_r_p2[i];

            r_c2p_p4[i][0] <= pmul(r_vp_p3[NXT[i]], mag32(r_s_p3[PRV[i]]),
                                   r_s_p3[PRV[i]][31]);
            r_c2p_p4[i][1] <= pmul(r_vp_p3[PRV[i]], mag32(r_s_p3[NXT[i]]),
                                   r_s_p3[NXT[i]][31]);
            r_x_p4[i] <= r_x_p3[i];
            r_u_p4[i] <= r_u_p3[i];
            r_r_p4[i] <= r_r_p3[i];

            r_c2_p5[i] <= sat32(WW'(prnd(r_c2p_p4[i][0])) - WW'(prnd(r_c2p_p4[i][1])));
            r_x_p5[i]  <= r_x_p4[i];
            r_u_p5[i]  <= r_u_p4[i];
            r_r_p5[i]  <= r_r_p4[i];

            // second half kick
            r_vn_p6[i] <= sat32(WW'(w_w[i]) + WW'(r_r_p5[i]));
            r_x_p6[i]  <= r_x_p5[i];

            r_dtp_p7[i] <= pmul(r_vn_p6[i], r_dt, 1'b0);
            r_vn_p7[i]  <= r_vn_p6[i];
            r_x_p7[i]   <= r_x_p6[i];
        end

        r_out.new_pos_x <= sat32(WW'(r_x_p7[0]) + WW'(prnd(r_dtp_p7[0])));
        r_out.new_pos_y <= sat32(WW'(r_x_p7[1]) + WW'(prnd(r_dtp_p7[1])));
        r_out.new_pos_z <= sat32(WW'(r_x_p7[2]) + WW'(prnd(r_dtp_p7[2])));
        r_out.new_vel_x <= r_vn_p7[0];
        r_out.new_vel_y <= r_vn_p7[1];
        r_out.new_vel_z <= r_vn_p7[2];
    end

    // ---------------- assertions ----------------
    a_result_has_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, NST))
        else $error("result strobe without a matching start");

    a_zero_kick_vel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_kick == '0) |-> (o_result.new_vel_x == $past(i_item.vel_x, NST)
            && o_result.new_vel_z == $past(i_item.vel_z, NST)))
        else $error("velocity changed with zero kick coefficient");

    a_zero_dt_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_dt == '0) |-> (o_result.new_pos_x == $past(i_item.pos_x, NST)
            && o_result.new_pos_y == $past(i_item.pos_y, NST)))
        else $error("position changed with zero time step");

endmodule
